### hw/rtl/sfsa_pkg.sv
// ----------------------------------------------------------------------------
// sfsa_pkg: shared types and constants of the smallest free slot allocator
// Widths of the slot number and heap counts, and the beat types.
// ----------------------------------------------------------------------------
package sfsa_pkg;

  localparam int NumSlots = 1024;
  localparam int SlotW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int CntW = $clog2(NumSlots + 1);
  localparam int KeyW = 32;

  typedef struct packed {
    logic [31:0] start_time;
    logic [31:0] release_time;
  } req_t;

  typedef struct packed {
    logic [9:0] slot_index;
    logic       no_slot;
  } rsp_t;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [SlotW-1:0] slot;
  } held_ent_t;

endpackage

### hw/rtl/sfsa_ram.sv
// ----------------------------------------------------------------------------
// sfsa_ram: single-port synchronous RAM
// A read every cycle, also beside a write; read data is registered.
// ----------------------------------------------------------------------------
module sfsa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hw/rtl/smallest_free_slot_allocator.sv
// ----------------------------------------------------------------------------
// smallest_free_slot_allocator: min-heap based slot allocator
//
//   channel | direction | type  | handshake
//   req     | in        | req_t | req_valid / req_ready
//   rsp     | out       | rsp_t | rsp_valid / rsp_ready
//
// One request at a time. A sift down reads both children and compares at each
// heap level, a sift up reads the parent and compares; each release due is
// handled before the allocation. No clearing pass is needed after reset. The
// next request is taken while a result waits in the output register, and work
// stalls only when that register is still full at finish.
// ----------------------------------------------------------------------------
module smallest_free_slot_allocator
  import sfsa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_CHK_RD  = 5'd1;
  localparam logic [4:0] S_CHK     = 5'd2;
  localparam logic [4:0] S_HR_LAST = 5'd3;
  localparam logic [4:0] S_HR_LW   = 5'd4;
  localparam logic [4:0] S_HR_L    = 5'd5;
  localparam logic [4:0] S_HR_R    = 5'd6;
  localparam logic [4:0] S_HR_CMP  = 5'd7;
  localparam logic [4:0] S_FI_RD   = 5'd8;
  localparam logic [4:0] S_FI_CMP  = 5'd9;
  localparam logic [4:0] S_ALLOC   = 5'd10;
  localparam logic [4:0] S_FR_TOP  = 5'd11;
  localparam logic [4:0] S_FR_LW   = 5'd12;
  localparam logic [4:0] S_FR_L    = 5'd13;
  localparam logic [4:0] S_FR_R    = 5'd14;
  localparam logic [4:0] S_FR_CMP  = 5'd15;
  localparam logic [4:0] S_HI_RD   = 5'd16;
  localparam logic [4:0] S_HI_CMP  = 5'd17;
  localparam logic [4:0] S_DONE    = 5'd18;

  logic [4:0]       state;
  logic [CntW-1:0]  held_count;
  logic [CntW-1:0]  free_count;
  req_t             cur;
  held_ent_t        moving;
  held_ent_t        lch;
  logic [SlotW-1:0] fmoving;
  logic [SlotW-1:0] flch;
  logic [SlotW-1:0] freed;
  logic [SlotW-1:0] slot;
  logic [CntW-1:0]  pos;
  logic [CntW-1:0]  hn;
  logic             has_r;
  logic             rsp_full;
  rsp_t             rsp_q;
  rsp_t             res;

  logic             h_we;
  logic [SlotW-1:0] h_addr;
  held_ent_t        h_wdata;
  held_ent_t        h_rdata;
  logic             f_we;
  logic [SlotW-1:0] f_addr;
  logic [SlotW-1:0] f_wdata;
  logic [SlotW-1:0] f_rdata;

  logic [CntW:0]    lidx;
  logic [CntW-1:0]  parent;
  logic             l_in;
  logic             r_in;

  sfsa_ram #(.Width($bits(held_ent_t)), .Depth(NumSlots)) u_held (
    .clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata)
  );

  sfsa_ram #(.Width(SlotW), .Depth(NumSlots)) u_free (
    .clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wdata), .rdata(f_rdata)
  );

  assign lidx   = {pos, 1'b1};
  assign parent = (pos - 1'b1) >> 1;
  assign l_in   = lidx < {1'b0, hn};
  assign r_in   = (lidx + 1'b1) < {1'b0, hn};
  assign has_r  = r_in;

  always_comb begin
    h_we    = 1'b0;
    h_addr  = '0;
    h_wdata = moving;
    f_we    = 1'b0;
    f_addr  = '0;
    f_wdata = fmoving;
    unique case (state)
      S_CHK_RD: h_addr = '0;
      S_HR_LAST: h_addr = hn[SlotW-1:0];
      S_HR_L: h_addr = lidx[SlotW-1:0];
      S_HR_R: h_addr = lidx[SlotW-1:0] + 1'b1;
      S_HR_CMP: begin
        h_we = 1'b1;
        h_addr = pos[SlotW-1:0];
        if (l_in) begin
          if (has_r && h_rdata.key < lch.key) begin
            if (h_rdata.key < moving.key) h_wdata = h_rdata;
          end else if (lch.key < moving.key) begin
            h_wdata = lch;
          end
        end
      end
      S_FI_RD: f_addr = parent[SlotW-1:0];
      S_FI_CMP: begin
        f_we = 1'b1;
        f_addr = pos[SlotW-1:0];
        if (pos != '0 && f_rdata > fmoving) f_wdata = f_rdata;
      end
      S_ALLOC: f_addr = '0;
      S_FR_TOP: f_addr = free_count[SlotW-1:0];
      S_FR_L: f_addr = lidx[SlotW-1:0];
      S_FR_R: f_addr = lidx[SlotW-1:0] + 1'b1;
      S_FR_CMP: begin
        f_we = 1'b1;
        f_addr = pos[SlotW-1:0];
        if (l_in) begin
          if (r_in && f_rdata < flch) begin
            if (f_rdata < fmoving) f_wdata = f_rdata;
          end else if (flch < fmoving) begin
            f_wdata = flch;
          end
        end
      end
      S_HI_RD: h_addr = parent[SlotW-1:0];
      S_HI_CMP: begin
        h_we = 1'b1;
        h_addr = pos[SlotW-1:0];
        if (pos != '0 && h_rdata.key > moving.key) h_wdata = h_rdata;
      end
      default: ;
    endcase
  end

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = rsp_full;
  assign rsp       = rsp_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held_count <= '0;
      free_count <= '0;
      rsp_full   <= 1'b0;
    end else begin
      if (state == S_DONE && (!rsp_full || rsp_ready)) begin
        rsp_full <= 1'b1;
      end else if (rsp_ready) begin
        rsp_full <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (req_valid) begin
          cur   <= req;
          state <= (held_count != '0) ? S_CHK_RD : S_ALLOC;
        end
        S_CHK_RD: state <= S_CHK;
        S_CHK: begin
          if (h_rdata.key <= cur.start_time) begin
            freed      <= h_rdata.slot;
            hn         <= held_count - 1'b1;
            held_count <= held_count - 1'b1;
            pos        <= '0;
            state      <= S_HR_LAST;
          end else begin
            state <= S_ALLOC;
          end
        end
        S_HR_LAST: state <= S_HR_LW;
        S_HR_LW: begin
          moving <= h_rdata;
          state  <= S_HR_L;
        end
        S_HR_L: state <= S_HR_R;
        S_HR_R: begin
          lch   <= h_rdata;
          state <= S_HR_CMP;
        end
        S_HR_CMP: begin
          if (h_wdata != moving || !l_in) begin
            if (l_in && r_in && h_rdata.key < lch.key && h_rdata.key < moving.key) begin
              pos <= lidx[CntW-1:0] + 1'b1;
              state <= S_HR_L;
            end else if (l_in && h_wdata == lch && lch.key < moving.key) begin
              pos <= lidx[CntW-1:0];
              state <= S_HR_L;
            end else begin
              pos <= free_count;
              fmoving <= freed;
              free_count <= free_count + 1'b1;
              state <= S_FI_RD;
            end
          end else begin
            pos <= free_count;
            fmoving <= freed;
            free_count <= free_count + 1'b1;
            state <= S_FI_RD;
          end
        end
        S_FI_RD: state <= S_FI_CMP;
        S_FI_CMP: begin
          if (pos != '0 && f_rdata > fmoving) begin
            pos <= parent;
            state <= S_FI_RD;
          end else begin
            state <= (held_count != '0) ? S_CHK_RD : S_ALLOC;
          end
        end
        S_ALLOC: begin
          if (held_count == CntW'(NumSlots)) begin
            res   <= '{slot_index: '0, no_slot: 1'b1};
            state <= S_DONE;
          end else if (free_count != '0) begin
            free_count <= free_count - 1'b1;
            state <= S_FR_TOP;
          end else begin
            slot <= held_count[SlotW-1:0];
            pos <= held_count;
            moving <= '{key: cur.release_time, slot: held_count[SlotW-1:0]};
            held_count <= held_count + 1'b1;
            state <= S_HI_RD;
          end
        end
        S_FR_TOP: begin
          slot  <= f_rdata;
          hn    <= free_count;
          pos   <= '0;
          state <= S_FR_LW;
        end
        S_FR_LW: begin
          fmoving <= f_rdata;
          state   <= S_FR_L;
        end
        S_FR_L: state <= S_FR_R;
        S_FR_R: begin
          flch  <= f_rdata;
          state <= S_FR_CMP;
        end
        S_FR_CMP: begin
          if (l_in && r_in && f_rdata < flch && f_rdata < fmoving) begin
            pos <= lidx[CntW-1:0] + 1'b1;
            state <= S_FR_L;
          end else if (l_in && !(r_in && f_rdata < flch) && flch < fmoving) begin
            pos <= lidx[CntW-1:0];
            state <= S_FR_L;
          end else begin
            pos <= held_count;
            moving <= '{key: cur.release_time, slot: slot};
            held_count <= held_count + 1'b1;
            state <= S_HI_RD;
          end
        end
        S_HI_RD: state <= S_HI_CMP;
        S_HI_CMP: begin
          if (pos != '0 && h_rdata.key > moving.key) begin
            pos <= parent;
            state <= S_HI_RD;
          end else begin
            res   <= '{slot_index: 10'(slot), no_slot: 1'b0};
            state <= S_DONE;
          end
        end
        S_DONE: if (!rsp_full || rsp_ready) begin
          rsp_q <= res;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (held_count <= CntW'(NumSlots)) && (free_count <= CntW'(NumSlots)))
    else $error("heap count above slot count");
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, held_count} + {1'b0, free_count}) <= (CntW+1)'(NumSlots))
    else $error("held plus free slots above slot count");
  a_done_rsp: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!rsp_full || rsp_ready)) |=> rsp_full && state == S_IDLE)
    else $error("finished result not loaded");
  a_noslot_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.no_slot) |-> rsp.slot_index == '0)
    else $error("refused request carries a slot");
`endif

endmodule
